@@ sv/phmd_pkg.sv @@
// ---------------------------------------------------------------------------
// phmd_pkg
// Shared types and constants for the proof-of-work max difficulty block.
// ---------------------------------------------------------------------------
package phmd_pkg;

   localparam int EDGE_W   = 6;
   localparam int SEC_W    = 32;
   localparam int HASH_W   = 64;
   localparam int DIV_STEPS = HASH_W;

   // default edge sizes
   localparam int BASE_EDGE_DEF      = 24;
   localparam int SECONDARY_EDGE_DEF = 29;

   // one input item
   typedef struct packed {
      logic [EDGE_W-1:0] edge_bits;
      logic [SEC_W-1:0]  secondary_scaling;
      logic [HASH_W-1:0] hash_prefix;
   } req_type;

   // one result item
   typedef struct packed {
      logic [HASH_W-1:0] max_difficulty;
      logic              saturated;
   } rsp_type;

   // state carried from cell to cell along the divider chain
   typedef struct packed {
      logic              valid;
      logic              sat;
      logic [HASH_W-1:0] rem;
      logic [HASH_W-1:0] quo;
      logic [HASH_W-1:0] den;
   } div_stage_type;

endpackage

@@ sv/phmd_scale.sv @@
// ---------------------------------------------------------------------------
// phmd_scale
// Head cell: picks the scaling value and flags items that saturate at once.
// ---------------------------------------------------------------------------
module phmd_scale #(
   parameter int BASE_EDGE      = phmd_pkg::BASE_EDGE_DEF,
   parameter int SECONDARY_EDGE = phmd_pkg::SECONDARY_EDGE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  phmd_pkg::req_type       in_data,
   output phmd_pkg::div_stage_type out_stage
);

   localparam logic [phmd_pkg::EDGE_W-1:0] BASE_CODE =
      phmd_pkg::EDGE_W'(BASE_EDGE);
   localparam logic [phmd_pkg::EDGE_W-1:0] SEC_CODE =
      phmd_pkg::EDGE_W'(SECONDARY_EDGE);

   logic [phmd_pkg::EDGE_W-1:0] shift_dist;
   logic [phmd_pkg::EDGE_W:0]   shamt;
   logic [phmd_pkg::HASH_W-1:0] scale;
   phmd_pkg::div_stage_type     stage_in, stage_ff;

   // (2 << distance) * edge is edge shifted by distance + 1, wrapped to 64 bits
   always_comb begin
      shift_dist = in_data.edge_bits - BASE_CODE;
      shamt      = {1'b0, shift_dist} + 1'b1;
      if (in_data.edge_bits == SEC_CODE) begin
         scale = {{(phmd_pkg::HASH_W-phmd_pkg::SEC_W){1'b0}}, in_data.secondary_scaling};
      end else if (in_data.edge_bits < BASE_CODE) begin
         scale = '0;
      end else begin
         scale = {{(phmd_pkg::HASH_W-phmd_pkg::EDGE_W){1'b0}}, in_data.edge_bits} << shamt;
      end
   end

   // quotient would not fit, or hash is zero
   always_comb begin
      stage_in.valid = in_valid;
      stage_in.sat   = (in_data.hash_prefix == '0) || (scale >= in_data.hash_prefix);
      stage_in.rem   = scale;
      stage_in.quo   = '0;
      stage_in.den   = in_data.hash_prefix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (enable) begin
         stage_ff.sat <= stage_in.sat;
         stage_ff.rem <= stage_in.rem;
         stage_ff.quo <= stage_in.quo;
         stage_ff.den <= stage_in.den;
      end
   end

   assign out_stage = stage_ff;

endmodule

@@ sv/phmd_div_cell.sv @@
// ---------------------------------------------------------------------------
// phmd_div_cell
// One restoring division step: one quotient bit per cell, passed onward.
// ---------------------------------------------------------------------------
module phmd_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  phmd_pkg::div_stage_type in_stage,
   output phmd_pkg::div_stage_type out_stage
);

   logic                        top;
   logic [phmd_pkg::HASH_W-1:0] shifted;
   logic                        take;
   phmd_pkg::div_stage_type     stage_in, stage_ff;

   // shift remainder, subtract divisor when it fits (bit 64 counts)
   always_comb begin
      top      = in_stage.rem[phmd_pkg::HASH_W-1];
      shifted  = {in_stage.rem[phmd_pkg::HASH_W-2:0], 1'b0};
      take     = top || (shifted >= in_stage.den);
      stage_in = in_stage;
      stage_in.rem = take ? (shifted - in_stage.den) : shifted;
      stage_in.quo = {in_stage.quo[phmd_pkg::HASH_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (enable) begin
         stage_ff.sat <= stage_in.sat;
         stage_ff.rem <= stage_in.rem;
         stage_ff.quo <= stage_in.quo;
         stage_ff.den <= stage_in.den;
      end
   end

   assign out_stage = stage_ff;

endmodule

@@ sv/phmd_out_buf.sv @@
// ---------------------------------------------------------------------------
// phmd_out_buf
// Output register plus one skid entry; stalls the chain only when both hold.
// ---------------------------------------------------------------------------
module phmd_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  phmd_pkg::div_stage_type in_stage,
   output logic                    advance,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output phmd_pkg::rsp_type       rsp_data
);

   phmd_pkg::rsp_type result;
   phmd_pkg::rsp_type out_ff, skid_ff;
   logic              out_valid_ff, skid_valid_ff;
   logic              out_free;

   // final result from the last cell
   always_comb begin
      result.max_difficulty = in_stage.sat ? '1 : in_stage.quo;
      result.saturated      = in_stage.sat || (&in_stage.quo);
   end

   assign out_free = !out_valid_ff || rsp_ready;
   assign advance  = !skid_valid_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (in_stage.valid) begin
         if (out_free) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_ff <= skid_ff;
         end
      end else if (in_stage.valid) begin
         if (out_free) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ sv/pow_hash_max_difficulty_top.sv @@
// Throughput: one item per cycle unless the skid entry is occupied; one head cell
// plus a chain of 64 division cells, each resolving one quotient bit, then an
// output register and skid. Back-pressure stalls the whole chain only once the
// skid entry is occupied.
// Reset (synchronous, active high) clears all valid bits; payload is not reset.
// ---------------------------------------------------------------------------
// pow_hash_max_difficulty_top
// Computes min(scaling * 2^64 / hash_prefix, 2^64 - 1) with a saturation flag.
// ---------------------------------------------------------------------------
module pow_hash_max_difficulty_top #(
   parameter int BASE_EDGE      = phmd_pkg::BASE_EDGE_DEF,
   parameter int SECONDARY_EDGE = phmd_pkg::SECONDARY_EDGE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  phmd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output phmd_pkg::rsp_type rsp_data
);

   logic                    advance;
   phmd_pkg::div_stage_type chain [phmd_pkg::DIV_STEPS+1];

   assign req_ready = advance;

   // head cell
   phmd_scale #(
      .BASE_EDGE      (BASE_EDGE),
      .SECONDARY_EDGE (SECONDARY_EDGE)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_stage (chain[0])
   );

   // division chain, one quotient bit per cell
   for (genvar i = 0; i < phmd_pkg::DIV_STEPS; i++) begin : g_cell
      phmd_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_stage  (chain[i]),
         .out_stage (chain[i+1])
      );
   end

   // result register and skid
   phmd_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (chain[phmd_pkg::DIV_STEPS]),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sv/phmd_checker.sv @@
// ---------------------------------------------------------------------------
// phmd_checker
// Port-level checks for the max difficulty block, bound to the top level.
// ---------------------------------------------------------------------------
module phmd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input phmd_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input phmd_pkg::rsp_type rsp_data
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // flag marks exactly the maximum value
   a_sat_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.saturated == (rsp_data.max_difficulty == '1)))
      else $error("saturated flag does not match result");

   // input stalls only while a result is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind pow_hash_max_difficulty_top phmd_checker u_phmd_checker (.*);

@@ sim/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the proof-of-work max difficulty block.
// Every record accepted on req_ is run through a local model of the scaling
// choice and the shifted divide. The expected result is queued in order, and
// each item leaving rsp_ is compared field by field with the oldest entry.
// A directed set covers the edge cases: zero hash, scaling equal to or just
// below the hash, zero scaling, and edge bits below the base size. Random
// phases follow, with idle and stall mixes on both sides. One phase holds
// rsp_ready low long enough for the pipeline to fill and back up into req_.
// ---------------------------------------------------------------------------
module tb;

   localparam int CLK_HALF    = 10;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 120;
   localparam int PHASE_ITEMS = 300;
   localparam int HOLD_LEN    = 400;

   // expected-result store with its own model of the block
   class difficulty_scoreboard;
      phmd_pkg::rsp_type expected_difficulty[$];
      int                errors = 0;

      function phmd_pkg::rsp_type predict_difficulty(phmd_pkg::req_type rec);
         logic [63:0]       scale;
         logic [127:0]      quo;
         phmd_pkg::rsp_type res;
         int                shift_dist;
         if (rec.edge_bits == phmd_pkg::SECONDARY_EDGE_DEF) begin
            scale = {32'b0, rec.secondary_scaling};
         end else if (rec.edge_bits < phmd_pkg::BASE_EDGE_DEF) begin
            scale = '0;
         end else begin
            shift_dist = rec.edge_bits - phmd_pkg::BASE_EDGE_DEF;
            if (shift_dist >= 64) begin
               scale = '0;
            end else begin
               // both factors kept at 64 bits so the product wraps
               scale = (64'd2 << shift_dist) * {58'b0, rec.edge_bits};
            end
         end
         if (rec.hash_prefix == '0 || scale >= rec.hash_prefix) begin
            res.max_difficulty = '1;
            res.saturated      = 1'b1;
         end else begin
            quo = {scale, 64'b0} / {64'b0, rec.hash_prefix};
            res.max_difficulty = quo[63:0];
            res.saturated      = &quo[63:0];
         end
         return res;
      endfunction

      function void note_record(phmd_pkg::req_type rec);
         expected_difficulty.push_back(predict_difficulty(rec));
      endfunction

      function void check_result(phmd_pkg::rsp_type got);
         phmd_pkg::rsp_type exp_res;
         if (expected_difficulty.size() == 0) begin
            $error("result with nothing expected: max_difficulty %h saturated %b",
                   got.max_difficulty, got.saturated);
            errors++;
            return;
         end
         exp_res = expected_difficulty.pop_front();
         if (got.max_difficulty !== exp_res.max_difficulty) begin
            $error("max_difficulty: expected %h, got %h",
                   exp_res.max_difficulty, got.max_difficulty);
            errors++;
         end
         if (got.saturated !== exp_res.saturated) begin
            $error("saturated: expected %b, got %b", exp_res.saturated, got.saturated);
            errors++;
         end
      endfunction

      function int pending_count();
         return expected_difficulty.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   phmd_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   phmd_pkg::rsp_type rsp_data;

   difficulty_scoreboard sb = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int hold_taken     = 0;
   int hold_cycles    = 0;
   int cycle_count    = 0;

   pow_hash_max_difficulty_top #(
      .BASE_EDGE      (phmd_pkg::BASE_EDGE_DEF),
      .SECONDARY_EDGE (phmd_pkg::SECONDARY_EDGE_DEF)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // monitor both channels on pre-edge values
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_data);
      end
      if (!reset && req_valid && req_ready) begin
         sb.note_record(req_data);
      end
   end

   // receiver: long hold-off when asked, otherwise random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_requests != hold_taken) begin
         rsp_ready   <= 1'b0;
         hold_taken  <= hold_requests;
         hold_cycles <= HOLD_LEN - 1;
      end else if (hold_cycles > 0) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   function automatic phmd_pkg::req_type make_record(logic [5:0] edge_val, logic [31:0] sec,
                                                     logic [63:0] hash);
      phmd_pkg::req_type rec;
      rec.edge_bits         = edge_val;
      rec.secondary_scaling = sec;
      rec.hash_prefix       = hash;
      return rec;
   endfunction

   // random record: mostly valid edge sizes, hashes spread over all magnitudes
   function automatic phmd_pkg::req_type random_record();
      logic [5:0]  edge_val;
      logic [31:0] sec;
      logic [63:0] hash;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         edge_val = 6'(phmd_pkg::SECONDARY_EDGE_DEF);
      end else if (pick == 2) begin
         edge_val = 6'($urandom_range(0, phmd_pkg::BASE_EDGE_DEF - 1));
      end else begin
         edge_val = 6'($urandom_range(phmd_pkg::BASE_EDGE_DEF, 63));
      end
      sec  = $urandom() >> $urandom_range(0, 31);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         hash = '0;
      end else if (pick < 3) begin
         hash = 64'($urandom_range(1, 255));
      end else if (pick < 5) begin
         // around the secondary scaling value, hitting the saturation boundary
         hash = {32'b0, sec} + 64'($urandom_range(0, 2)) - 64'd1;
      end else begin
         hash = {$urandom(), $urandom()} >> $urandom_range(0, 63);
      end
      return make_record(edge_val, sec, hash);
   endfunction

   // offer one item, with random idle cycles in front of it
   task automatic send_item(input phmd_pkg::req_type rec);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rec;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic run_random_phase(input int send_pct, input int recv_pct, input int count);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         send_item(random_record());
      end
   endtask

   // stimulus
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed cases, no idling
      send_item(make_record(6'd29, 32'd0, 64'd1));                        // zero scaling
      send_item(make_record(6'd29, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
      send_item(make_record(6'd29, 32'd5, 64'd0));                        // zero hash
      send_item(make_record(6'd29, 32'd1000, 64'd1000));                  // scaling equals hash
      send_item(make_record(6'd29, 32'd1000, 64'd1001));
      send_item(make_record(6'd29, 32'd999, 64'd1000));
      send_item(make_record(6'd29, 32'hFFFF_FFFF, 64'd1));
      send_item(make_record(6'd24, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
      send_item(make_record(6'd24, 32'd0, 64'd49));
      send_item(make_record(6'd63, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF));
      send_item(make_record(6'd63, 32'hFFFF_FFFF, 64'd1));
      send_item(make_record(6'd23, 32'hFFFF_FFFF, 64'd12345));            // below base edge
      send_item(make_record(6'd0, 32'd0, 64'd0));
      send_item(make_record(6'd0, 32'hAAAA_5555, 64'h5555_AAAA_5555_AAAA));
      send_item(make_record(6'd30, 32'h5555_AAAA, 64'h8000_0000_0000_0000));
      send_item(make_record(6'd28, 32'd7, 64'h8000_0000_0000_0001));
      send_item(make_record(6'd45, 32'd1, 64'h0000_0123_4567_89AB));
      send_item(make_record(6'd62, 32'd2, 64'h0000_1F00_0000_0000));

      // random phases
      run_random_phase(0, 0, PHASE_ITEMS);
      run_random_phase(53, 0, PHASE_ITEMS);
      run_random_phase(0, 53, PHASE_ITEMS);
      run_random_phase(33, 33, PHASE_ITEMS);

      // pressure: receiver holds off while the sender keeps offering
      hold_requests++;
      run_random_phase(0, 0, PHASE_ITEMS);

      req_valid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sb.errors == 0 && sb.pending_count() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/phmd_pkg.sv
sv/phmd_scale.sv
sv/phmd_div_cell.sv
sv/phmd_out_buf.sv
sv/pow_hash_max_difficulty_top.sv
sv/phmd_checker.sv
sim/tb.sv
